### sv/assert_macros.svh
// Assertion helpers for the sparse entry store.
// Clocked on i_clk, quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property with a message.
`define SCES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define SCES_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

### sv/sces_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sces_pkg
// Shared sizes, codes and types of the sparse coordinate entry store.
// ---------------------------------------------------------------------------
package sces_pkg;

    localparam int CAPACITY  = 64;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 10;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DEFAULT_DIM = DIM_W'(10);

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = CFG_IDX_W'(1);

    // Opcodes
    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Update command broadcast to every cell
    typedef struct packed {
        logic             wr_val;   // matching cell takes a new value
        logic             shift;    // cells at/after the match take from upper neighbor
        logic             append;   // tail cell takes the new entry
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_cell_ctrl;

    // One stored entry, as handed between neighbors
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

### sv/sces_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sces_cell
// One slot of the entry chain: holds an entry, compares it against the
// incoming position, and overwrites, shifts or appends on command.
// ---------------------------------------------------------------------------
module sces_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cmp_en,
    input  wire logic [sces_pkg::ROW_W-1:0] i_key_row,
    input  wire logic [sces_pkg::COL_W-1:0] i_key_col,
    input  wire logic                    i_live,
    input  wire logic                    i_tail,
    input  wire sces_pkg::t_cell_ctrl    i_ctrl,
    input  wire sces_pkg::t_entry        i_upper,
    input  wire logic                    i_seen,
    output sces_pkg::t_entry             o_entry,
    output logic                         o_seen,
    output logic                         o_match,
    output logic [sces_pkg::VAL_W-1:0]   o_hit_value
);
    import sces_pkg::*;

    t_entry r_entry;
    logic   r_match;
    logic   n_match;

    // Position compare, taken when an item is accepted
    assign n_match = i_live && (r_entry.row == i_key_row) && (r_entry.col == i_key_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmp_en) begin
            r_match <= n_match;
        end
    end

    // Entry storage: overwrite, shift down from the upper neighbor, or append
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_val && r_match) begin
            r_entry.value <= i_ctrl.value;
        end else if (i_ctrl.shift && o_seen) begin
            r_entry <= i_upper;
        end else if (i_ctrl.append && i_tail) begin
            r_entry.row   <= i_ctrl.row;
            r_entry.col   <= i_ctrl.col;
            r_entry.value <= i_ctrl.value;
        end
    end

    // Match seen at or below this slot ripples up the chain
    assign o_seen      = i_seen || r_match;
    assign o_entry     = r_entry;
    assign o_match     = r_match;
    assign o_hit_value = r_match ? r_entry.value : '0;

endmodule

`default_nettype wire

### sv/sparse_coordinate_entry_store_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Result: registered, loaded when the chain updates; the update waits while the output is stalled.
// Flow: o_stall holds off a new item until the last one has updated the chain; every cell
//   compares when an item is accepted, then the chain overwrites, shifts or appends.
// Reset: synchronous, active low; entry count cleared, row/col counts back to 10.
//   Entry storage is not cleared; slots at or above the count are never read.
// ---------------------------------------------------------------------------
// sparse_coordinate_entry_store_unit
// Coordinate-list sparse matrix store: a chain of CAPACITY cells kept in
// insertion order, with set (write/delete/append) and get operations.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_coordinate_entry_store_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_opcode,
    input  wire logic [sces_pkg::ROW_W-1:0]    i_row,
    input  wire logic [sces_pkg::COL_W-1:0]    i_col,
    input  wire logic signed [sces_pkg::VAL_W-1:0] i_value_in,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [sces_pkg::VAL_W-1:0]  o_value_out,
    output logic [1:0]                         o_status,
    output logic [sces_pkg::CNT_W-1:0]         o_entries_held,
    // config write
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sces_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sces_pkg::DIM_W-1:0]    i_cfg_data
);
    import sces_pkg::*;

    // control state
    logic             r_busy;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_col_count;

    // captured item
    logic             r_op;
    logic             r_oob;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [VAL_W-1:0] r_val;

    // result register
    logic [VAL_W-1:0] r_out_value;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_held;
    logic [VAL_W-1:0] n_out_value;
    t_status          n_out_status;

    // chain wiring
    logic                      accept;
    logic                      do_upd;
    logic                      hit;
    logic                      full;
    logic                      val_zero;
    logic [VAL_W-1:0]          hit_value;
    t_cell_ctrl                ctrl;
    logic [CAPACITY-1:0]       live;
    logic [CAPACITY-1:0]       tail;
    logic [CAPACITY-1:0]       match;
    logic [CAPACITY:0]         seen;
    t_entry                    entry  [CAPACITY+1];
    logic [VAL_W-1:0]          hit_val [CAPACITY];

    assign accept      = i_valid && !o_stall;
    assign o_stall     = r_busy;
    assign do_upd      = r_busy && (!r_out_valid || !i_stall);
    assign o_cfg_ready = 1'b1;

    // Cell chain
    assign seen[0]         = 1'b0;
    assign entry[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign live[g] = CNT_W'(g) < r_count;
        assign tail[g] = CNT_W'(g) == r_count;

        sces_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmp_en    (accept),
            .i_key_row   (i_row),
            .i_key_col   (i_col),
            .i_live      (live[g]),
            .i_tail      (tail[g]),
            .i_ctrl      (ctrl),
            .i_upper     (entry[g+1]),
            .i_seen      (seen[g]),
            .o_entry     (entry[g]),
            .o_seen      (seen[g+1]),
            .o_match     (match[g]),
            .o_hit_value (hit_val[g])
        );
    end

    // Gather the matched value (at most one cell matches)
    always_comb begin
        hit_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            hit_value = hit_value | hit_val[k];
        end
    end

    // Update decode
    always_comb begin
        hit      = |match;
        full     = r_count == CNT_W'(CAPACITY);
        val_zero = r_val == '0;

        ctrl.row    = r_row;
        ctrl.col    = r_col;
        ctrl.value  = r_val;
        ctrl.wr_val = do_upd && !r_oob && (r_op == OP_SET) && hit && !val_zero;
        ctrl.shift  = do_upd && !r_oob && (r_op == OP_SET) && hit && val_zero;
        ctrl.append = do_upd && !r_oob && (r_op == OP_SET) && !hit && !val_zero && !full;

        n_count = r_count;
        if (ctrl.shift) begin
            n_count = r_count - CNT_W'(1);
        end else if (ctrl.append) begin
            n_count = r_count + CNT_W'(1);
        end

        n_out_value  = '0;
        n_out_status = ST_OK;
        if (r_oob) begin
            n_out_status = ST_BOUNDS;
        end else if (r_op == OP_GET) begin
            n_out_value = hit_value;
        end else if (!hit && !val_zero && full) begin
            n_out_status = ST_FULL;
        end
    end

    // Control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_row_count <= DEFAULT_DIM;
            r_col_count <= DEFAULT_DIM;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (do_upd) begin
                r_busy <= 1'b0;
            end

            if (do_upd) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Captured item and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_row <= i_row;
            r_col <= i_col;
            r_val <= i_value_in;
            // bound of 1024 or above admits every 10-bit position
            r_oob <= ({1'b0, i_row} >= r_row_count) || ({1'b0, i_col} >= r_col_count);
        end
        if (do_upd) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_held   <= n_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_value_out    = r_out_value;
    assign o_status       = r_out_status;
    assign o_entries_held = r_out_held;

    // Checks
    `SCES_ASSERT(a_match_unique, !r_busy || $onehot0(match), "more than one cell matched")
    `SCES_ASSERT(a_count_cap, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SCES_ASSERT_NEXT(a_upd_result, do_upd, r_out_valid && !r_busy, "update gave no result")
    `SCES_ASSERT(a_full_status,
        !r_out_valid || r_out_status != ST_FULL || r_out_held == CNT_W'(CAPACITY),
        "full status while not full")

endmodule

`default_nettype wire

### tb/sv/tb_sparse_coordinate_entry_store_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sparse_coordinate_entry_store_unit
// Self-checking bench for the sparse coordinate entry store. A ledger class
// keeps its own copy of the entry list and the size registers, predicts the
// result of every accepted item and checks the results in order. A short
// directed run is followed by phases at different matrix sizes with random
// sets, deletes and gets, random gaps on both sides and one long output hold.
// ---------------------------------------------------------------------------
module tb_sparse_coordinate_entry_store_unit;

    import sces_pkg::*;

    localparam int unsigned DIM_MAX = 1024;
    // Indexes past the register list; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_status          status;
        logic [CNT_W-1:0] held;
    } store_result_t;

    // Predicted store contents and the results still owed by the block
    class coord_store_ledger;
        logic [DIM_W-1:0] rows_reg;
        logic [DIM_W-1:0] cols_reg;
        logic [ROW_W-1:0] ent_row[$];
        logic [COL_W-1:0] ent_col[$];
        logic [VAL_W-1:0] ent_val[$];
        store_result_t    owed_results[$];
        int unsigned      mismatches;

        function new();
            rows_reg    = DEFAULT_DIM;
            cols_reg    = DEFAULT_DIM;
            mismatches  = 0;
        endfunction

        // Size registers above the matrix limit act as the limit
        function int unsigned span(logic [DIM_W-1:0] reg_val);
            return (reg_val > DIM_MAX) ? DIM_MAX : int'(reg_val);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            if (idx == CFG_ROW_COUNT) rows_reg = data;
            else if (idx == CFG_COL_COUNT) cols_reg = data;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // Apply one accepted item and queue the result it must produce
        function void log_item(logic op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                               logic [VAL_W-1:0] val);
            store_result_t res;
            int slot;
            res.value  = '0;
            res.status = ST_OK;
            slot       = -1;
            if (row >= span(rows_reg) || col >= span(cols_reg)) begin
                res.status = ST_BOUNDS;
            end else begin
                foreach (ent_row[i])
                    if (slot < 0 && ent_row[i] == row && ent_col[i] == col) slot = i;
                if (op == OP_GET) begin
                    if (slot >= 0) res.value = ent_val[slot];
                end else if (slot >= 0) begin
                    // hit: overwrite, or delete and close the gap
                    if (val != '0) begin
                        ent_val[slot] = val;
                    end else begin
                        ent_row.delete(slot);
                        ent_col.delete(slot);
                        ent_val.delete(slot);
                    end
                end else if (val != '0) begin
                    if (ent_row.size() >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        ent_row.push_back(row);
                        ent_col.push_back(col);
                        ent_val.push_back(val);
                    end
                end
            end
            res.held = CNT_W'(ent_row.size());
            owed_results.push_back(res);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch, %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void check_result(logic [VAL_W-1:0] value, t_status status,
                                   logic [CNT_W-1:0] held);
            store_result_t want;
            if (owed_results.size() == 0) begin
                flag("result with no item outstanding, value", 32'h0, value);
                return;
            end
            want = owed_results.pop_front();
            if (value !== want.value) flag("value_out", want.value, value);
            if (status !== want.status) flag("status", want.status, status);
            if (held !== want.held) flag("entries_held", want.held, held);
        endfunction

        function bit clean();
            return mismatches == 0 && owed_results.size() == 0;
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_opcode;
    logic [ROW_W-1:0]        i_row;
    logic [COL_W-1:0]        i_col;
    logic signed [VAL_W-1:0] i_value_in;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VAL_W-1:0] o_value_out;
    logic [1:0]              o_status;
    logic [CNT_W-1:0]        o_entries_held;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [DIM_W-1:0]        i_cfg_data;

    coord_store_ledger ledger = new();

    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;
    bit hold_wanted = 1'b0;

    sparse_coordinate_entry_store_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_value_in     (i_value_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value_out    (o_value_out),
        .o_status       (o_status),
        .o_entries_held (o_entries_held),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check every item taken, then draw the next stall
    initial begin : result_side
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (o_valid && !i_stall) begin
                    ledger.check_result(o_value_out, t_status'(o_status), o_entries_held);
                    stall_left = recv_idle ? $urandom_range(0, 9) : 0;
                end
                if (hold_wanted) begin
                    hold_wanted = 1'b0;
                    hold_left   = 300;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Offer one item after an optional gap; valid stays up for a following item
    task automatic send_item(logic op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic [VAL_W-1:0] v);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_row      <= r;
        i_col      <= c;
        i_value_in <= v;
        do @(posedge i_clk); while (o_stall);
        ledger.log_item(op, r, c, v);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_register(idx, data);
    endtask

    // Both size registers plus one write to an unused index
    task automatic configure(int unsigned rows, int unsigned cols);
        cfg_write(CFG_ROW_COUNT, DIM_W'(rows));
        cfg_write(CFG_COL_COUNT, DIM_W'(cols));
        cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, DIM_W'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'hffff_ffff;
            5:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Mostly positions already held or inside the matrix, some around the edge
    task automatic pick_spot(output logic [ROW_W-1:0] r, output logic [COL_W-1:0] c);
        int unsigned k;
        int unsigned rs;
        int unsigned cs;
        int unsigned idx;
        k  = $urandom_range(0, 99);
        rs = ledger.span(ledger.rows_reg);
        cs = ledger.span(ledger.cols_reg);
        if (k < 40 && ledger.ent_row.size() > 0) begin
            idx = $urandom_range(0, ledger.ent_row.size() - 1);
            r   = ledger.ent_row[idx];
            c   = ledger.ent_col[idx];
        end else if (k < 88 && rs > 0 && cs > 0) begin
            r = ROW_W'($urandom_range(0, rs - 1));
            c = COL_W'($urandom_range(0, cs - 1));
        end else if (k < 94) begin
            r = ROW_W'($urandom_range(0, rs));
            c = COL_W'($urandom_range(0, cs));
        end else begin
            r = ROW_W'($urandom());
            c = COL_W'($urandom());
        end
    endtask

    // Fill mode leans on nonzero sets so the store runs into its capacity
    task automatic random_item(bit fill);
        logic             op;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [VAL_W-1:0] v;
        op = ($urandom_range(0, 99) < (fill ? 10 : 45)) ? OP_GET : OP_SET;
        pick_spot(r, c);
        v = draw_value();
        if (fill && v == '0 && $urandom_range(0, 3) != 0) v = $urandom() | 32'h1;
        send_item(op, r, c, v);
    endtask

    task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned items,
                             bit fill, bit squeeze);
        configure(rows, cols);
        send_idle = squeeze ? 1'b0 : ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
        if (squeeze) hold_wanted = 1'b1;
        repeat (items) random_item(fill);
        drain_results();
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_opcode    <= OP_SET;
        i_row       <= '0;
        i_col       <= '0;
        i_value_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data  <= DEFAULT_DIM;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run on the reset size of 10 x 10
        send_item(OP_GET, 10'd0, 10'd0, 32'h0);             // empty store
        send_item(OP_SET, 10'd0, 10'd0, 32'h7fff_ffff);
        send_item(OP_SET, 10'd9, 10'd9, 32'h8000_0000);
        send_item(OP_SET, 10'd3, 10'd4, 32'hffff_ffff);
        send_item(OP_GET, 10'd0, 10'd0, 32'h0);
        send_item(OP_GET, 10'd9, 10'd9, 32'hffff_ffff);
        send_item(OP_SET, 10'd10, 10'd0, 32'h5);            // row just past the edge
        send_item(OP_GET, 10'd0, 10'd10, 32'h0);            // column just past the edge
        send_item(OP_SET, 10'd1023, 10'd1023, 32'h1);
        send_item(OP_SET, 10'd0, 10'd0, 32'h1);             // overwrite
        send_item(OP_SET, 10'd5, 10'd5, 32'h0);             // zero with no match
        send_item(OP_SET, 10'd0, 10'd0, 32'h0);             // delete head, tail shifts
        send_item(OP_GET, 10'd9, 10'd9, 32'h0);
        send_item(OP_GET, 10'd3, 10'd4, 32'h0);
        send_item(OP_GET, 10'd0, 10'd0, 32'h0);
        send_item(OP_SET, 10'd9, 10'd0, 32'h5555_5555);
        send_item(OP_SET, 10'd0, 10'd9, 32'haaaa_aaaa);
        send_item(OP_GET, 10'd9, 10'd0, 32'h0);
        send_item(OP_SET, 10'd9, 10'd9, 32'h0);             // delete the head, the rest shifts
        send_item(OP_GET, 10'd0, 10'd9, 32'h0);
        drain_results();

        // Random phases over a range of sizes, extremes included
        run_phase(10, 10, 200, 1'b0, 1'b0);
        run_phase(12, 12, 300, 1'b1, 1'b0);
        run_phase(12, 12, 150, 1'b0, 1'b0);
        run_phase(1024, 1024, 300, 1'b1, 1'b1);
        run_phase(2047, 2047, 200, 1'b0, 1'b0);
        run_phase(0, 5, 15, 1'b0, 1'b0);
        run_phase(5, 0, 15, 1'b0, 1'b0);
        run_phase(1, 1, 100, 1'b0, 1'b0);
        run_phase(1024, 1, 150, 1'b1, 1'b0);
        run_phase(3, 2047, 150, 1'b0, 1'b0);
        run_phase(8, 9, 200, 1'b0, 1'b0);

        // Catch any stray result after the last one owed
        repeat (4) @(posedge i_clk);
        if (ledger.clean())
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
